### rtl/core/ssdbd_pkg.sv
// Types, stage map and constants for the SSD anchor box decoder.
package ssdbd_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_CX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_CY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_W  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_H  = 2'd3;

    localparam logic [15:0] SCALE_CENTRE_RST = 16'd6554;
    localparam logic [15:0] SCALE_SIZE_RST   = 16'd13107;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [31:0] ONE_Q30   = 32'd1073741824;

    localparam int EXP_BITS = 12;
    localparam logic [30:0] POW2_BIT_Q30 [EXP_BITS] = '{
        31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
        31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
        31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544
    };

    // Pipeline stage map
    localparam int ST_IN       = 0;
    localparam int ST_MUL      = 1;
    localparam int ST_EXP      = 2;
    localparam int ST_MANT0    = 3;
    localparam int ST_MANT_END = ST_MANT0 + EXP_BITS - 1;
    localparam int ST_LIN1     = ST_MANT_END + 1;
    localparam int ST_LIN2     = ST_LIN1 + 1;
    localparam int ST_SIZE_MUL = ST_LIN2 + 1;
    localparam int ST_SIZE_SH  = ST_SIZE_MUL + 1;
    localparam int ST_CORNER   = ST_SIZE_SH + 1;
    localparam int NUM_STAGES  = ST_CORNER + 1;

    localparam int OUT_W = 20;

    // One axis of the box: lane 0 is x/width, lane 1 is y/height
    typedef struct packed {
        logic [15:0]        anc_c;
        logic [15:0]        anc_s;
        logic signed [15:0] dc;
        logic signed [15:0] ds;
        logic [31:0]        sprod;
        logic signed [32:0] t;
        logic signed [48:0] cprod;
        logic signed [63:0] yprod;
        logic signed [21:0] ctr;
        logic signed [4:0]  n;
        logic [27:0]        f;
        logic [31:0]        m;
        logic [19:0]        c1;
        logic [47:0]        mprod;
        logic [28:0]        size;
        logic [OUT_W-1:0]   cmin;
        logic [OUT_W-1:0]   cmax;
    } lane_t;

    typedef struct {
        logic  last;
        logic  clamped;
        lane_t ln [2];
    } stage_t;

    // Saturate to signed 20 bits; top bit of the result flags a clip
    function automatic logic [OUT_W:0] sat20(input logic signed [31:0] v);
        logic [OUT_W:0] r;
        if (v > 32'sd524287) begin
            r = {1'b1, 20'h7FFFF};
        end else if (v < -32'sd524288) begin
            r = {1'b1, 20'h80000};
        end else begin
            r = {1'b0, v[OUT_W-1:0]};
        end
        return r;
    endfunction

endpackage

### rtl/core/ssd_box_decoder.sv
// SSD anchor box decoder: centre-form deltas to saturated corner-form boxes.
// Each input beat is registered through the input, multiply, exp, mantissa, linear, size and corner stages.
// Throughput: one beat per cycle; each stage holds while the one after it is full
// and stalled, and empty stages fill behind a stalled output.
// Depth is set by the twelve-step exp mantissa chain, one multiply per stage.
// Reset (aresetn low, synchronous) clears all valid bits and loads scale defaults.
module ssd_box_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ssdbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssdbd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // delta_x, delta_y, delta_w, delta_h, anchor_cx, anchor_cy, anchor_w, anchor_h
    input  logic [127:0]                       s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // corner_x_min, corner_y_min, corner_x_max, corner_y_max
    output logic [79:0]                        m_tdata,
    output logic                               m_tlast,
    // clamped
    output logic [0:0]                         m_tuser
);

    localparam int NST = ssdbd_pkg::NUM_STAGES;

    logic [15:0] scale_cx_reg, scale_cy_reg, scale_w_reg, scale_h_reg;
    logic [15:0] scale_c [2];
    logic [15:0] scale_s [2];

    logic [NST-1:0]    vld_reg;
    logic [NST-1:0]    stage_en;
    ssdbd_pkg::stage_t pipe_reg  [NST];
    ssdbd_pkg::stage_t pipe_next [NST];
    ssdbd_pkg::stage_t stage_in  [NST];
    ssdbd_pkg::stage_t in_stage;

    assign scale_c[0] = scale_cx_reg;
    assign scale_c[1] = scale_cy_reg;
    assign scale_s[0] = scale_w_reg;
    assign scale_s[1] = scale_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_cx_reg <= ssdbd_pkg::SCALE_CENTRE_RST;
            scale_cy_reg <= ssdbd_pkg::SCALE_CENTRE_RST;
            scale_w_reg  <= ssdbd_pkg::SCALE_SIZE_RST;
            scale_h_reg  <= ssdbd_pkg::SCALE_SIZE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ssdbd_pkg::REG_SCALE_CX: scale_cx_reg <= cfg_wdata;
                ssdbd_pkg::REG_SCALE_CY: scale_cy_reg <= cfg_wdata;
                ssdbd_pkg::REG_SCALE_W:  scale_w_reg  <= cfg_wdata;
                ssdbd_pkg::REG_SCALE_H:  scale_h_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Unpack the input beat
    always_comb begin
        in_stage = '{default: '0};
        in_stage.last = s_tlast;
        in_stage.ln[0].dc    = signed'(s_tdata[15:0]);
        in_stage.ln[1].dc    = signed'(s_tdata[31:16]);
        in_stage.ln[0].ds    = signed'(s_tdata[47:32]);
        in_stage.ln[1].ds    = signed'(s_tdata[63:48]);
        in_stage.ln[0].anc_c = s_tdata[79:64];
        in_stage.ln[1].anc_c = s_tdata[95:80];
        in_stage.ln[0].anc_s = s_tdata[111:96];
        in_stage.ln[1].anc_s = s_tdata[127:112];
    end

    always_comb begin
        stage_in[0] = in_stage;
        for (int k = 1; k < NST; k++) begin
            stage_in[k] = pipe_reg[k - 1];
        end
    end

    // A stage advances when it is empty or the stage after it advances
    always_comb begin
        stage_en[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k + 1];
        end
    end

    assign s_tready = stage_en[0];

    always_comb begin
        ssdbd_pkg::stage_t    nxt;
        logic [63:0]          up;
        logic signed [63:0]   ys;
        logic signed [48:0]   cs;
        logic [5:0]           sh;
        logic signed [31:0]   xmin;
        logic signed [31:0]   xmax;
        logic [ssdbd_pkg::OUT_W:0] smin;
        logic [ssdbd_pkg::OUT_W:0] smax;
        up   = '0;
        ys   = '0;
        cs   = '0;
        sh   = '0;
        xmin = '0;
        xmax = '0;
        smin = '0;
        smax = '0;
        for (int k = 0; k < NST; k++) begin
            nxt = stage_in[k];
            if (k == ssdbd_pkg::ST_CORNER) begin
                nxt.clamped = 1'b0;
            end
            for (int l = 0; l < 2; l++) begin
                if (k == ssdbd_pkg::ST_IN) begin
                    nxt.ln[l].sprod = 32'(nxt.ln[l].anc_s) * 32'(scale_c[l]);
                    nxt.ln[l].t = 33'(nxt.ln[l].ds) * signed'({17'b0, scale_s[l]});
                end else if (k == ssdbd_pkg::ST_MUL) begin
                    nxt.ln[l].cprod = 49'(nxt.ln[l].dc) * signed'({17'b0, nxt.ln[l].sprod});
                    nxt.ln[l].yprod = 64'(nxt.ln[l].t)
                                      * signed'({33'b0, ssdbd_pkg::LOG2E_Q30});
                end else if (k == ssdbd_pkg::ST_EXP) begin
                    cs = (nxt.ln[l].cprod + 49'sd134217728) >>> 28;
                    nxt.ln[l].ctr = 22'(cs) + signed'({6'b0, nxt.ln[l].anc_c});
                    ys = (nxt.ln[l].yprod + 64'sd536870912) >>> 30;
                    nxt.ln[l].n = signed'(ys[32:28]);
                    nxt.ln[l].f = ys[27:0];
                    nxt.ln[l].m = ssdbd_pkg::ONE_Q30;
                end else if (k inside {[ssdbd_pkg::ST_MANT0:ssdbd_pkg::ST_MANT_END]}) begin
                    // Multiply in 2^(2^-i) for each set fraction bit, top bit first
                    if (nxt.ln[l].f[27 - (k - ssdbd_pkg::ST_MANT0)]) begin
                        up = 64'(nxt.ln[l].m)
                             * 64'(ssdbd_pkg::POW2_BIT_Q30[k - ssdbd_pkg::ST_MANT0]);
                        up = up + 64'd536870912;
                        nxt.ln[l].m = 32'(up >> 30);
                    end
                end else if (k == ssdbd_pkg::ST_LIN1) begin
                    up = 64'(nxt.ln[l].m) * 64'(nxt.ln[l].f[15:0]) + 64'd134217728;
                    nxt.ln[l].c1 = 20'(up >> 28);
                end else if (k == ssdbd_pkg::ST_LIN2) begin
                    up = 64'(nxt.ln[l].c1) * 64'(ssdbd_pkg::LN2_Q30) + 64'd536870912;
                    nxt.ln[l].m = nxt.ln[l].m + 32'(up >> 30);
                end else if (k == ssdbd_pkg::ST_SIZE_MUL) begin
                    nxt.ln[l].mprod = 48'(nxt.ln[l].m) * 48'(nxt.ln[l].anc_s);
                end else if (k == ssdbd_pkg::ST_SIZE_SH) begin
                    // Scale by 2^n: round and shift right by 30 - n
                    sh = 6'(7'sd30 - 7'(nxt.ln[l].n));
                    up = 64'(nxt.ln[l].mprod) + (64'd1 << (sh - 6'd1));
                    nxt.ln[l].size = 29'(up >> sh);
                end else if (k == ssdbd_pkg::ST_CORNER) begin
                    xmin = 32'(nxt.ln[l].ctr) - signed'({4'b0, nxt.ln[l].size[28:1]});
                    xmax = xmin + signed'({3'b0, nxt.ln[l].size});
                    smin = ssdbd_pkg::sat20(xmin);
                    smax = ssdbd_pkg::sat20(xmax);
                    nxt.ln[l].cmin = smin[ssdbd_pkg::OUT_W-1:0];
                    nxt.ln[l].cmax = smax[ssdbd_pkg::OUT_W-1:0];
                    nxt.clamped = nxt.clamped | smin[ssdbd_pkg::OUT_W]
                                  | smax[ssdbd_pkg::OUT_W];
                end
            end
            pipe_next[k] = nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (stage_en[k]) begin
                    vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NST; k++) begin
            if (stage_en[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign m_tvalid   = vld_reg[NST-1];
    assign m_tdata    = {pipe_reg[NST-1].ln[1].cmax, pipe_reg[NST-1].ln[0].cmax,
                         pipe_reg[NST-1].ln[1].cmin, pipe_reg[NST-1].ln[0].cmin};
    assign m_tlast    = pipe_reg[NST-1].last;
    assign m_tuser[0] = pipe_reg[NST-1].clamped;

endmodule

### tb/sv/ssd_box_checker.sv
// Watches both streams of the box decoder, predicts each decoded box and compares.
module ssd_box_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ssdbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssdbd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // delta_x, delta_y, delta_w, delta_h, anchor_cx, anchor_cy, anchor_w, anchor_h
    input  logic [127:0]                        s_tdata,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // corner_x_min, corner_y_min, corner_x_max, corner_y_max
    input  logic [79:0]                         m_tdata,
    input  logic                                m_tlast,
    // clamped
    input  logic [0:0]                          m_tuser,
    output int                                  fail_count,
    output int                                  pending
);

    localparam longint LOG2E_FX = 64'sd1549082005;
    localparam longint LN2_FX   = 64'sd744261118;
    localparam longint OUT_HI   = 64'sd524287;
    localparam longint OUT_LO   = -64'sd524288;

    // 2^(2^-i) in Q1.30 for fraction bits i = 1..12
    localparam longint ROOT2_STEP [12] = '{
        64'sd1518500250, 64'sd1276901417, 64'sd1170923762, 64'sd1121280436,
        64'sd1097253708, 64'sd1085434106, 64'sd1079572136, 64'sd1076653033,
        64'sd1075196443, 64'sd1074468888, 64'sd1074105294, 64'sd1073923544
    };

    typedef struct packed {
        logic signed [19:0] x_min;
        logic signed [19:0] y_min;
        logic signed [19:0] x_max;
        logic signed [19:0] y_max;
        logic               end_of_image;
        logic               clamped;
    } box_t;

    logic [15:0] scale_cx;
    logic [15:0] scale_cy;
    logic [15:0] scale_w;
    logic [15:0] scale_h;

    box_t boxes_due [$];
    int   fails;
    int   boxes_seen;

    // Round half up: floor((v + half ulp) / 2^sh)
    function automatic longint round_shift(input longint v, input int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint decode_centre(input longint delta, input longint anc_c,
                                             input longint anc_s, input longint scale);
        return anc_c + round_shift(delta * (anc_s * scale), 28);
    endfunction

    // anchor size * exp(delta * scale), via 2^y with y split into integer and fraction
    function automatic longint decode_extent(input longint delta, input longint anc_s,
                                             input longint scale);
        longint y;
        longint n;
        longint f;
        longint m;
        longint c1;
        y = round_shift(delta * scale * LOG2E_FX, 30);
        n = y >>> 28;
        f = y - (n <<< 28);
        m = longint'(1) << 30;
        for (int i = 0; i < 12; i++) begin
            if (f[27 - i]) begin
                m = round_shift(m * ROOT2_STEP[i], 30);
            end
        end
        // the low sixteen fraction bits go in linearly
        c1 = round_shift(m * longint'(f[15:0]), 28);
        m = m + round_shift(c1 * LN2_FX, 30);
        return round_shift(m * anc_s, 30 - int'(n));
    endfunction

    function automatic logic [19:0] clip20(input longint v, inout logic hit);
        if (v > OUT_HI) begin
            hit = 1'b1;
            return 20'h7FFFF;
        end
        if (v < OUT_LO) begin
            hit = 1'b1;
            return 20'h80000;
        end
        return v[19:0];
    endfunction

    function automatic box_t decode_box(input logic [127:0] d, input logic last);
        longint cx;
        longint cy;
        longint w;
        longint h;
        longint xmin;
        longint ymin;
        logic   hit;
        box_t   b;
        hit = 1'b0;
        cx = decode_centre(longint'($signed(d[15:0])), longint'(d[79:64]),
                           longint'(d[111:96]), longint'(scale_cx));
        cy = decode_centre(longint'($signed(d[31:16])), longint'(d[95:80]),
                           longint'(d[127:112]), longint'(scale_cy));
        w = decode_extent(longint'($signed(d[47:32])), longint'(d[111:96]),
                          longint'(scale_w));
        h = decode_extent(longint'($signed(d[63:48])), longint'(d[127:112]),
                          longint'(scale_h));
        // max corners come from the unclipped min corners
        xmin = cx - (w >>> 1);
        ymin = cy - (h >>> 1);
        b.x_min = clip20(xmin, hit);
        b.y_min = clip20(ymin, hit);
        b.x_max = clip20(xmin + w, hit);
        b.y_max = clip20(ymin + h, hit);
        b.end_of_image = last;
        b.clamped = hit;
        return b;
    endfunction

    always @(posedge aclk) begin
        box_t seen;
        box_t due;
        if (!aresetn) begin
            scale_cx = 16'd6554;
            scale_cy = 16'd6554;
            scale_w  = 16'd13107;
            scale_h  = 16'd13107;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    ssdbd_pkg::REG_SCALE_CX: scale_cx = cfg_wdata;
                    ssdbd_pkg::REG_SCALE_CY: scale_cy = cfg_wdata;
                    ssdbd_pkg::REG_SCALE_W:  scale_w  = cfg_wdata;
                    ssdbd_pkg::REG_SCALE_H:  scale_h  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                boxes_due.insert(boxes_due.size(), decode_box(s_tdata, s_tlast));
            end
            if (m_tvalid && m_tready) begin
                seen = '{x_min: m_tdata[19:0], y_min: m_tdata[39:20],
                         x_max: m_tdata[59:40], y_max: m_tdata[79:60],
                         end_of_image: m_tlast, clamped: m_tuser[0]};
                boxes_seen++;
                if (boxes_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("box %0d arrived with nothing outstanding", boxes_seen);
                    end
                end else begin
                    due = boxes_due.pop_front();
                    if (seen.x_min !== due.x_min || seen.y_min !== due.y_min ||
                        seen.x_max !== due.x_max || seen.y_max !== due.y_max ||
                        seen.end_of_image !== due.end_of_image ||
                        seen.clamped !== due.clamped) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("box %0d: expected x %0d..%0d y %0d..%0d eoi %0b clamp %0b",
                                     boxes_seen, due.x_min, due.x_max, due.y_min, due.y_max,
                                     due.end_of_image, due.clamped);
                            $display("box %0d: got      x %0d..%0d y %0d..%0d eoi %0b clamp %0b",
                                     boxes_seen, seen.x_min, seen.x_max, seen.y_min,
                                     seen.y_max, seen.end_of_image, seen.clamped);
                        end
                    end
                end
            end
        end
        fail_count <= fails;
        pending <= boxes_due.size();
    end

endmodule

### tb/sv/tb.sv
// Top of the box decoder regression: clock, reset, stimulus, stalls and verdict.
module tb;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [ssdbd_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [ssdbd_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    // delta_x, delta_y, delta_w, delta_h, anchor_cx, anchor_cy, anchor_w, anchor_h
    logic [127:0]                       s_tdata = '0;
    logic                               s_tlast = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    // corner_x_min, corner_y_min, corner_x_max, corner_y_max
    logic [79:0]                        m_tdata;
    logic                               m_tlast;
    // clamped
    logic [0:0]                         m_tuser;
    logic [9:0]                         stall_tick = '0;
    int                                 fail_count;
    int                                 pending;

    ssd_box_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    ssd_box_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: full rate, mostly ready, one in three, then mostly stalled
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 10'd1;
        case (stall_tick[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 9) < 7);
            2'd2: m_tready <= (stall_tick % 3 == 0);
            default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    function automatic logic [127:0] pack_box(input logic [15:0] dx, input logic [15:0] dy,
                                              input logic [15:0] dw, input logic [15:0] dh,
                                              input logic [15:0] acx, input logic [15:0] acy,
                                              input logic [15:0] aw, input logic [15:0] ah);
        return {ah, aw, acy, acx, dh, dw, dy, dx};
    endfunction

    function automatic logic [15:0] rand_delta();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 8191) - 4096);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            2: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_anchor();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Hold the beat until the decoder takes it; leave tvalid high for the next one
    task automatic push_box(input logic [127:0] d, input logic last);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        do @(posedge aclk); while (pending != 0);
    endtask

    // Write all four scales once the pipeline has emptied
    task automatic retune(input logic [15:0] cx, input logic [15:0] cy,
                          input logic [15:0] w, input logic [15:0] h);
        logic [15:0] vals [4];
        vals = '{cx, cy, w, h};
        drain();
        repeat (25) @(posedge aclk);
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ssdbd_pkg::CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic directed_boxes();
        push_box(pack_box(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'd32768, 16'd32768, 16'd16384, 16'd16384), 1'b0);
        push_box(pack_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        push_box(pack_box(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
        // zero anchor size: corners collapse onto the anchor centre
        push_box(pack_box(16'h3039, 16'hF830, 16'h7FFF, 16'h8000,
                          16'd40000, 16'd1234, 16'h0000, 16'h0000), 1'b0);
        push_box(pack_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000), 1'b0);
        push_box(pack_box(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                          16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001), 1'b1);
        push_box(pack_box(16'h8000, 16'h8000, 16'h1000, 16'h1000,
                          16'h0000, 16'h0000, 16'd2048, 16'd2048), 1'b0);
        push_box(pack_box(16'h1000, 16'hF000, 16'h1000, 16'hF000,
                          16'd30000, 16'd20000, 16'd8000, 16'd12000), 1'b0);
        push_box(pack_box(16'h0001, 16'h0001, 16'h0001, 16'h0001,
                          16'h0001, 16'h0001, 16'h0001, 16'h0001), 1'b1);
        push_box(pack_box(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                          16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA), 1'b0);
        push_box(pack_box(16'h0000, 16'h0000, 16'h6000, 16'h6000,
                          16'hFFFF, 16'h0000, 16'hC000, 16'hC000), 1'b0);
        push_box(pack_box(16'hC000, 16'h4000, 16'hA000, 16'hA000,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1);
        s_tvalid <= 1'b0;
    endtask

    task automatic stream_boxes(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && left > 0; k++) begin
                push_box(pack_box(rand_delta(), rand_delta(), rand_delta(), rand_delta(),
                                  rand_anchor(), rand_anchor(), rand_anchor(),
                                  rand_anchor()),
                         1'($urandom_range(0, 1)));
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 || left == 0) begin
                s_tvalid <= 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset scales first
        directed_boxes();
        stream_boxes(300);

        // zero scales: deltas must have no effect
        retune(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        stream_boxes(250);

        // full scales: large deltas drive the corners into saturation
        retune(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        directed_boxes();
        stream_boxes(280);

        retune(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        stream_boxes(250);

        retune(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        stream_boxes(200);

        retune(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        stream_boxes(200);

        retune(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        stream_boxes(150);

        retune(16'd6554, 16'd6554, 16'd13107, 16'd13107);
        stream_boxes(100);

        drain();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
